### rtl/stok_pkg.sv
// ----------------------------------------------------------------------------
// stok_pkg
// Shared types and constants of the source tokenizer: token kinds, the token
// record and the per-byte record group that moves from front to back.
// ----------------------------------------------------------------------------
package stok_pkg;

    localparam logic [4:0] K_NUM     = 5'd0;
    localparam logic [4:0] K_IDENT   = 5'd1;
    localparam logic [4:0] K_FUNC    = 5'd2;
    localparam logic [4:0] K_RETURN  = 5'd3;
    localparam logic [4:0] K_PLUS    = 5'd4;
    localparam logic [4:0] K_MINUS   = 5'd5;
    localparam logic [4:0] K_STAR    = 5'd6;
    localparam logic [4:0] K_DIV     = 5'd7;
    localparam logic [4:0] K_CARET   = 5'd8;
    localparam logic [4:0] K_EQ      = 5'd9;
    localparam logic [4:0] K_LPAREN  = 5'd10;
    localparam logic [4:0] K_RPAREN  = 5'd11;
    localparam logic [4:0] K_LBRACE  = 5'd12;
    localparam logic [4:0] K_RBRACE  = 5'd13;
    localparam logic [4:0] K_COMMA   = 5'd14;
    localparam logic [4:0] K_SEMI    = 5'd15;
    localparam logic [4:0] K_UNKNOWN = 5'd16;
    localparam logic [4:0] K_END     = 5'd17;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_US    = 8'h5F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;

    // keyword tracker: 0 none, 1..4 prefix of func, 5..10 prefix of return
    localparam logic [3:0] KW_NONE      = 4'd0;
    localparam logic [3:0] KW_FUNC_1    = 4'd1;
    localparam logic [3:0] KW_FUNC_DONE = 4'd4;
    localparam logic [3:0] KW_RET_1     = 4'd5;
    localparam logic [3:0] KW_RET_DONE  = 4'd10;

    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTRW  = $clog2(QDEPTH);

    // slots: 0 flushed token, 1 operator/unknown, 2 token open at end, 3 end
    localparam int unsigned NSLOTS = 4;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] line;
        logic [15:0] column;
        logic [15:0] length;
    } rec_t;

    typedef struct packed {
        logic [NSLOTS-1:0]       mask;
        rec_t [NSLOTS-1:0]       recs;
    } bundle_t;

endpackage

### rtl/stok_if.sv
// ----------------------------------------------------------------------------
// stok_if
// Valid/ready channels of the source tokenizer: byte input and token output.
// ----------------------------------------------------------------------------
interface stok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_req;
    logic       last;

    modport source (output valid, output byte_req, output last, input ready);
    modport sink   (input valid, input byte_req, input last, output ready);
endinterface

interface stok_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [15:0] token_length;
    logic        run_last;

    modport source (output valid, output token_kind, output start_line,
                    output start_column, output token_length, output run_last,
                    input ready);
    modport sink   (input valid, input token_kind, input start_line,
                    input start_column, input token_length, input run_last,
                    output ready);
endinterface

### rtl/source_tokenizer.sv
// ----------------------------------------------------------------------------
// source_tokenizer
// Streaming lexer: source bytes in, token records (kind, start line, start
// column, length) out. Skips whitespace and comments, flags END at the end.
//
//   channel     dir  beat payload
//   byte_in     in   byte_req[7:0], last
//   token_out   out  token_kind[4:0], start_line, start_column,
//                    token_length[15:0], run_last
//
// One byte accepted per cycle while the 2-entry group queue has room.
// Records leave one per cycle while token_out is ready; a byte that yields
// 2 or 3 records holds off input once the queue fills. Output is registered.
// Reset empties queue and output; line, column and start position go to 1.
// Either side may stall on its own; bytes after END are taken and dropped.
// ----------------------------------------------------------------------------
module source_tokenizer #(
    parameter int POS_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    stok_in_if.sink    byte_in,
    stok_out_if.source token_out
);
    import stok_pkg::*;

    logic    q_ready, q_push, q_not_empty, q_pop;
    bundle_t q_in, q_head;

    stok_front #(
        .POS_BITS (POS_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_in),
        .q_ready (q_ready),
        .q_push  (q_push),
        .q_data  (q_in)
    );

    stok_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .not_full  (q_ready),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    stok_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .token_out   (token_out)
    );

endmodule

### rtl/stok_front.sv
// ----------------------------------------------------------------------------
// stok_front
// Scanner front: takes one byte per beat, updates position and scan state,
// and builds the group of token records that the byte causes.
// ----------------------------------------------------------------------------
module stok_front #(
    parameter int POS_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    stok_in_if.sink           byte_in,
    input  logic              q_ready,
    output logic              q_push,
    output stok_pkg::bundle_t q_data
);
    import stok_pkg::*;

    typedef enum logic [6:0] {
        M_IDLE  = 7'b0000001,
        M_NUM   = 7'b0000010,
        M_IDENT = 7'b0000100,
        M_SLASH = 7'b0001000,
        M_LINE  = 7'b0010000,
        M_BLOCK = 7'b0100000,
        M_BSTAR = 7'b1000000
    } mode_t;

    localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);

    mode_t               mode_reg, mode_next;
    logic                seen_reg, seen_next;
    logic [POS_BITS-1:0] line_reg, line_next;
    logic [POS_BITS-1:0] col_reg, col_next;
    logic [POS_BITS-1:0] tsl_reg, tsl_next;
    logic [POS_BITS-1:0] tsc_reg, tsc_next;
    logic [POS_BITS-1:0] len_reg, len_next;
    logic [3:0]          kw_reg, kw_next;
    logic                fin_reg, fin_next;

    logic       accept;
    logic       adv;
    logic       do_idle;
    logic [7:0] b;
    logic       is_digit, is_alpha, is_space, is_word;
    bundle_t    bnd;

    function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
        return (&v) ? v : v + POS_ONE;
    endfunction

    function automatic logic [15:0] clip(input logic [POS_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic logic [4:0] op_kind(input logic [7:0] c);
        logic [4:0] k;
        unique case (c)
            8'h2B:   k = K_PLUS;
            8'h2D:   k = K_MINUS;
            8'h2A:   k = K_STAR;
            8'h2F:   k = K_DIV;
            8'h5E:   k = K_CARET;
            8'h3D:   k = K_EQ;
            8'h28:   k = K_LPAREN;
            8'h29:   k = K_RPAREN;
            8'h7B:   k = K_LBRACE;
            8'h7D:   k = K_RBRACE;
            8'h2C:   k = K_COMMA;
            8'h3B:   k = K_SEMI;
            default: k = K_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic logic [3:0] kw_step(input logic [3:0] m, input logic [7:0] c);
        logic [7:0] want;
        logic       ok;
        ok = 1'b1;
        unique case (m)
            4'd1:    want = 8'h75; // u
            4'd2:    want = 8'h6E; // n
            4'd3:    want = 8'h63; // c
            4'd5:    want = 8'h65; // e
            4'd6:    want = 8'h74; // t
            4'd7:    want = 8'h75; // u
            4'd8:    want = 8'h72; // r
            4'd9:    want = 8'h6E; // n
            default:
            begin
                want = 8'h00;
                ok   = 1'b0;
            end
        endcase
        return (ok && c == want) ? m + 4'd1 : KW_NONE;
    endfunction

    function automatic logic [4:0] tok_kind(input mode_t m, input logic [3:0] kw);
        logic [4:0] k;
        if (m == M_NUM)
            k = K_NUM;
        else if (m == M_SLASH)
            k = K_DIV;
        else if (kw == KW_FUNC_DONE)
            k = K_FUNC;
        else if (kw == KW_RET_DONE)
            k = K_RETURN;
        else
            k = K_IDENT;
        return k;
    endfunction

    assign b        = byte_in.byte_req;
    assign is_digit = (b >= 8'h30) && (b <= 8'h39);
    assign is_alpha = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    assign is_word  = is_alpha || is_digit || (b == CH_US);
    assign is_space = (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));

    assign byte_in.ready = q_ready;
    assign accept        = byte_in.valid && q_ready;

    always_comb
    begin
        mode_next = mode_reg;
        seen_next = seen_reg;
        line_next = line_reg;
        col_next  = col_reg;
        tsl_next  = tsl_reg;
        tsc_next  = tsc_reg;
        len_next  = len_reg;
        kw_next   = kw_reg;
        fin_next  = fin_reg;
        adv       = 1'b0;
        do_idle   = 1'b0;
        bnd.mask  = '0;

        // token ended by this byte
        bnd.recs[0].kind   = tok_kind(mode_reg, kw_reg);
        bnd.recs[0].line   = clip(tsl_reg);
        bnd.recs[0].column = clip(tsc_reg);
        bnd.recs[0].length = (mode_reg == M_SLASH) ? 16'd1 : clip(len_reg);

        bnd.recs[1].kind   = op_kind(b);
        bnd.recs[1].line   = clip(line_reg);
        bnd.recs[1].column = clip(col_reg);
        bnd.recs[1].length = 16'd1;

        if (b != CH_NUL)
        begin
            unique case (mode_reg)
                M_NUM:
                begin
                    if (is_digit || (b == CH_DOT && !seen_reg))
                    begin
                        if (b == CH_DOT)
                            seen_next = 1'b1;
                        len_next = sat_inc(len_reg);
                        adv      = 1'b1;
                    end
                    else
                    begin
                        bnd.mask[0] = 1'b1;
                        do_idle     = 1'b1;
                    end
                end
                M_IDENT:
                begin
                    if (is_word)
                    begin
                        len_next = sat_inc(len_reg);
                        kw_next  = kw_step(kw_reg, b);
                        adv      = 1'b1;
                    end
                    else
                    begin
                        bnd.mask[0] = 1'b1;
                        do_idle     = 1'b1;
                    end
                end
                M_SLASH:
                begin
                    if (b == CH_SLASH)
                    begin
                        mode_next = M_LINE;
                        adv       = 1'b1;
                    end
                    else if (b == CH_STAR)
                    begin
                        mode_next = M_BLOCK;
                        adv       = 1'b1;
                    end
                    else
                    begin
                        bnd.mask[0] = 1'b1;
                        do_idle     = 1'b1;
                    end
                end
                M_LINE:
                begin
                    if (b == CH_LF)
                        mode_next = M_IDLE;
                    adv = 1'b1;
                end
                M_BLOCK:
                begin
                    if (b == CH_STAR)
                        mode_next = M_BSTAR;
                    adv = 1'b1;
                end
                M_BSTAR:
                begin
                    if (b == CH_SLASH)
                        mode_next = M_IDLE;
                    else if (b != CH_STAR)
                        mode_next = M_BLOCK;
                    adv = 1'b1;
                end
                default:
                begin
                    do_idle = 1'b1;
                end
            endcase

            if (do_idle)
            begin
                mode_next = M_IDLE;
                adv       = 1'b1;
                if (is_digit || is_alpha || b == CH_US || b == CH_SLASH)
                begin
                    tsl_next = line_reg;
                    tsc_next = col_reg;
                    len_next = POS_ONE;
                end
                if (is_space)
                begin
                end
                else if (is_digit)
                begin
                    seen_next = 1'b0;
                    mode_next = M_NUM;
                end
                else if (is_alpha || b == CH_US)
                begin
                    kw_next   = (b == 8'h66) ? KW_FUNC_1 : (b == 8'h72) ? KW_RET_1 : KW_NONE;
                    mode_next = M_IDENT;
                end
                else if (b == CH_SLASH)
                begin
                    mode_next = M_SLASH;
                end
                else
                begin
                    bnd.mask[1] = 1'b1;
                end
            end

            if (adv)
            begin
                if (b == CH_LF)
                begin
                    line_next = sat_inc(line_reg);
                    col_next  = POS_ONE;
                end
                else
                begin
                    col_next = sat_inc(col_reg);
                end
            end
        end

        // token still open when the source ends
        bnd.recs[2].kind   = tok_kind(mode_next, kw_next);
        bnd.recs[2].line   = clip(tsl_next);
        bnd.recs[2].column = clip(tsc_next);
        bnd.recs[2].length = (mode_next == M_SLASH) ? 16'd1 : clip(len_next);

        bnd.recs[3].kind   = K_END;
        bnd.recs[3].line   = clip(line_next);
        bnd.recs[3].column = clip(col_next);
        bnd.recs[3].length = 16'd0;

        if (b == CH_NUL || byte_in.last)
        begin
            bnd.mask[2] = (mode_next == M_NUM) || (mode_next == M_IDENT)
                          || (mode_next == M_SLASH);
            bnd.mask[3] = 1'b1;
            mode_next   = M_IDLE;
            fin_next    = 1'b1;
        end
    end

    assign q_push = accept && !fin_reg && (bnd.mask != '0);
    assign q_data = bnd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            seen_reg <= 1'b0;
            line_reg <= POS_ONE;
            col_reg  <= POS_ONE;
            tsl_reg  <= POS_ONE;
            tsc_reg  <= POS_ONE;
            len_reg  <= '0;
            kw_reg   <= KW_NONE;
            fin_reg  <= 1'b0;
        end
        else if (accept && !fin_reg)
        begin
            mode_reg <= mode_next;
            seen_reg <= seen_next;
            line_reg <= line_next;
            col_reg  <= col_next;
            tsl_reg  <= tsl_next;
            tsc_reg  <= tsc_next;
            len_reg  <= len_next;
            kw_reg   <= kw_next;
            fin_reg  <= fin_next;
        end
    end

endmodule

### rtl/stok_queue.sv
// ----------------------------------------------------------------------------
// stok_queue
// Short queue of record groups between scanner front and emitter back.
// ----------------------------------------------------------------------------
module stok_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  stok_pkg::bundle_t push_data,
    output logic              not_full,
    input  logic              pop,
    output logic              not_empty,
    output stok_pkg::bundle_t head
);
    import stok_pkg::*;

    bundle_t          slots_reg [QDEPTH];
    logic [QPTRW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTRW:0]   count_reg, count_next;
    logic             do_push, do_pop;

    assign not_full  = (count_reg < (QPTRW+1)'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign head      = slots_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + (QPTRW+1)'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - (QPTRW+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QPTRW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QPTRW'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_data;
    end

endmodule

### rtl/stok_back.sv
// ----------------------------------------------------------------------------
// stok_back
// Emitter back: unpacks each record group and sends its records one beat
// at a time, flagging the last record of the group.
// ----------------------------------------------------------------------------
module stok_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_not_empty,
    input  stok_pkg::bundle_t q_head,
    output logic              q_pop,
    stok_out_if.source        token_out
);
    import stok_pkg::*;

    logic [NSLOTS-1:0]  mask_reg, mask_next;
    rec_t [NSLOTS-1:0]  recs_reg;
    logic               out_valid_reg, out_valid_next;
    rec_t               out_rec_reg;
    logic               out_last_reg;

    logic               out_free, pick, load;
    logic [1:0]         idx;
    logic [NSLOTS-1:0]  mask_after;

    assign out_free = !out_valid_reg || token_out.ready;
    assign pick     = out_free && (mask_reg != '0);

    always_comb
    begin
        priority if (mask_reg[0])
            idx = 2'd0;
        else if (mask_reg[1])
            idx = 2'd1;
        else if (mask_reg[2])
            idx = 2'd2;
        else
            idx = 2'd3;
    end

    assign mask_after = pick ? (mask_reg & ~(NSLOTS'(1) << idx)) : mask_reg;
    assign load       = (mask_after == '0) && q_not_empty;
    assign q_pop      = load;
    assign mask_next  = load ? q_head.mask : mask_after;

    always_comb
    begin
        if (pick)
            out_valid_next = 1'b1;
        else if (token_out.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            recs_reg <= q_head.recs;
        if (pick)
        begin
            out_rec_reg  <= recs_reg[idx];
            out_last_reg <= (mask_after == '0);
        end
    end

    assign token_out.valid        = out_valid_reg;
    assign token_out.token_kind   = out_rec_reg.kind;
    assign token_out.start_line   = out_rec_reg.line;
    assign token_out.start_column = out_rec_reg.column;
    assign token_out.token_length = out_rec_reg.length;
    assign token_out.run_last     = out_last_reg;

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for source_tokenizer. Feeds one source stream of
// directed text, random token-shaped text with noise, a short keyword line
// and one end-of-input case, under several idle/stall mixes. A model
// inside the scoreboard predicts every token record, checked in order.
// ----------------------------------------------------------------------------
module tb;
    import stok_pkg::*;

    localparam int          LIMIT_CYCLES = 1_000_000;
    localparam int          PHASE_BYTES  = 70;
    localparam logic [7:0]  CH_TAB       = 8'h09;
    localparam logic [7:0]  CH_CR        = 8'h0D;
    localparam logic [7:0]  CH_SPACE     = 8'h20;
    localparam string       FUNC_TEXT    = "func";
    localparam string       RET_TEXT     = "return";
    localparam string       OP_TEXT      = "+-*/^=(){},;";
    localparam string       WORD_TEXT    =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

    typedef enum logic [2:0] {
        S_IDLE, S_NUM, S_IDENT, S_SLASH, S_LCMT, S_BCMT, S_BSTAR
    } scan_e;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] line;
        logic [15:0] column;
        logic [15:0] length;
        logic        run_last;
    } token_t;

    class token_scoreboard;
        scan_e       mode;
        bit          dot_seen;
        logic [15:0] line_no;
        logic [15:0] col_no;
        logic [15:0] tok_line;
        logic [15:0] tok_col;
        logic [15:0] tok_len;
        logic [3:0]  kw;
        bit          ended;
        token_t      pending_tokens[$];
        token_t      step_tokens[$];
        int          errors;
        int          bytes_taken;
        int          bytes_dropped;
        int          tokens_matched;
        bit [17:0]   kinds_seen;

        function new();
            mode = S_IDLE;
            dot_seen = 0;
            line_no = 16'd1;
            col_no = 16'd1;
            tok_line = 16'd1;
            tok_col = 16'd1;
            tok_len = 16'd0;
            kw = KW_NONE;
            ended = 0;
            errors = 0;
            bytes_taken = 0;
            bytes_dropped = 0;
            tokens_matched = 0;
            kinds_seen = '0;
        endfunction

        function logic [15:0] sat(logic [15:0] v);
            return (v == 16'hFFFF) ? v : v + 16'd1;
        endfunction

        function bit is_digit(logic [7:0] b);
            return b >= "0" && b <= "9";
        endfunction

        function bit is_alpha(logic [7:0] b);
            return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
        endfunction

        function bit is_space(logic [7:0] b);
            return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
        endfunction

        function logic [4:0] op_kind(logic [7:0] b);
            case (b)
                "+":     return K_PLUS;
                "-":     return K_MINUS;
                "*":     return K_STAR;
                "/":     return K_DIV;
                "^":     return K_CARET;
                "=":     return K_EQ;
                "(":     return K_LPAREN;
                ")":     return K_RPAREN;
                "{":     return K_LBRACE;
                "}":     return K_RBRACE;
                ",":     return K_COMMA;
                ";":     return K_SEMI;
                default: return K_UNKNOWN;
            endcase
        endfunction

        function logic [3:0] kw_next(logic [3:0] m, logic [7:0] b);
            if (m >= KW_FUNC_1 && m < KW_FUNC_DONE)
                return (b == FUNC_TEXT[m]) ? m + 4'd1 : KW_NONE;
            if (m >= KW_RET_1 && m < KW_RET_DONE)
                return (b == RET_TEXT[m - KW_RET_1 + 1]) ? m + 4'd1 : KW_NONE;
            return KW_NONE;
        endfunction

        function void move_pos(logic [7:0] b);
            if (b == CH_LF)
            begin
                line_no = sat(line_no);
                col_no = 16'd1;
            end
            else
                col_no = sat(col_no);
        endfunction

        function void add(logic [4:0] kind, logic [15:0] ln, logic [15:0] col,
                          logic [15:0] len);
            token_t t;
            t.kind = kind;
            t.line = ln;
            t.column = col;
            t.length = len;
            t.run_last = 1'b0;
            step_tokens = {step_tokens, t};
        endfunction

        function void open_token();
            tok_line = line_no;
            tok_col = col_no;
            tok_len = 16'd1;
        endfunction

        function void scan_fresh(logic [7:0] b);
            mode = S_IDLE;
            if (is_space(b))
            begin
                move_pos(b);
                return;
            end
            if (is_digit(b))
            begin
                open_token();
                dot_seen = 0;
                mode = S_NUM;
            end
            else if (is_alpha(b) || b == CH_US)
            begin
                open_token();
                kw = (b == "f") ? KW_FUNC_1 : (b == "r") ? KW_RET_1 : KW_NONE;
                mode = S_IDENT;
            end
            else if (b == CH_SLASH)
            begin
                open_token();
                mode = S_SLASH;
            end
            else
                add(op_kind(b), line_no, col_no, 16'd1);
            move_pos(b);
        endfunction

        function void flush();
            case (mode)
                S_NUM:   add(K_NUM, tok_line, tok_col, tok_len);
                S_IDENT: add(kw == KW_FUNC_DONE ? K_FUNC :
                             kw == KW_RET_DONE ? K_RETURN : K_IDENT,
                             tok_line, tok_col, tok_len);
                S_SLASH: add(K_DIV, tok_line, tok_col, 16'd1);
                default: ;
            endcase
            mode = S_IDLE;
        endfunction

        function void take_byte(logic [7:0] b, logic l);
            bytes_taken++;
            if (ended)
            begin
                bytes_dropped++;
                return;
            end
            if (b != CH_NUL)
            begin
                case (mode)
                    S_NUM:
                        if (is_digit(b) || (b == CH_DOT && !dot_seen))
                        begin
                            if (b == CH_DOT)
                                dot_seen = 1;
                            tok_len = sat(tok_len);
                            move_pos(b);
                        end
                        else
                        begin
                            flush();
                            scan_fresh(b);
                        end
                    S_IDENT:
                        if (is_alpha(b) || is_digit(b) || b == CH_US)
                        begin
                            tok_len = sat(tok_len);
                            kw = kw_next(kw, b);
                            move_pos(b);
                        end
                        else
                        begin
                            flush();
                            scan_fresh(b);
                        end
                    S_SLASH:
                        if (b == CH_SLASH)
                        begin
                            mode = S_LCMT;
                            move_pos(b);
                        end
                        else if (b == CH_STAR)
                        begin
                            mode = S_BCMT;
                            move_pos(b);
                        end
                        else
                        begin
                            flush();
                            scan_fresh(b);
                        end
                    S_LCMT:
                    begin
                        if (b == CH_LF)
                            mode = S_IDLE;
                        move_pos(b);
                    end
                    S_BCMT:
                    begin
                        if (b == CH_STAR)
                            mode = S_BSTAR;
                        move_pos(b);
                    end
                    S_BSTAR:
                    begin
                        if (b == CH_SLASH)
                            mode = S_IDLE;
                        else if (b != CH_STAR)
                            mode = S_BCMT;
                        move_pos(b);
                    end
                    default:
                        scan_fresh(b);
                endcase
            end
            if (b == CH_NUL || l)
            begin
                flush();
                add(K_END, line_no, col_no, 16'd0);
                ended = 1;
            end
            if (step_tokens.size() > 0)
                step_tokens[step_tokens.size() - 1].run_last = 1'b1;
            pending_tokens = {pending_tokens, step_tokens};
            step_tokens.delete();
        endfunction

        function void report(string name, int unsigned e, int unsigned a);
            $display("%0t: token %0d %s mismatch: expected %0d, actual %0d",
                     $time, tokens_matched, name, e, a);
            errors++;
        endfunction

        function void match_token(token_t got);
            token_t exp;
            if (got.kind < 18)
                kinds_seen[got.kind] = 1'b1;
            if (pending_tokens.size() == 0)
            begin
                $display("%0t: unexpected token: expected none, actual kind %0d line %0d col %0d",
                         $time, got.kind, got.line, got.column);
                errors++;
                return;
            end
            exp = pending_tokens.pop_front();
            if (got.kind !== exp.kind)
                report("kind", exp.kind, got.kind);
            if (got.line !== exp.line)
                report("start_line", exp.line, got.line);
            if (got.column !== exp.column)
                report("start_column", exp.column, got.column);
            if (got.length !== exp.length)
                report("token_length", exp.length, got.length);
            if (got.run_last !== exp.run_last)
                report("run_last", exp.run_last, got.run_last);
            tokens_matched++;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycles = 0;
    int   sent_count = 0;
    int   idle_pct = 0;
    int   stall_pct = 0;

    token_scoreboard sb = new();

    stok_in_if  byte_in();
    stok_out_if token_out();

    source_tokenizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_in),
        .token_out (token_out)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d tokens outstanding",
                     cycles, sb.pending_tokens.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
        token_out.ready <= rst_n && ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_in.valid && byte_in.ready)
                sb.take_byte(byte_in.byte_req, byte_in.last);
            if (token_out.valid && token_out.ready)
                sb.match_token({token_out.token_kind, token_out.start_line,
                                token_out.start_column, token_out.token_length,
                                token_out.run_last});
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic l = 1'b0);
        while ($urandom_range(99) < idle_pct)
        begin
            byte_in.valid <= 1'b0;
            @(posedge clk);
        end
        byte_in.valid <= 1'b1;
        byte_in.byte_req <= b;
        byte_in.last <= l;
        @(posedge clk);
        while (!byte_in.ready)
            @(posedge clk);
        sent_count++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic wait_drained();
        byte_in.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_tokens.size() != 0)
            @(posedge clk);
    endtask

    task automatic gen_word();
        int sel;
        int n;
        sel = $urandom_range(5);
        case (sel)
            0: send_text(FUNC_TEXT);
            1: send_text(RET_TEXT);
            2:
            begin
                if ($urandom_range(1))
                    send_text("funcs");
                else
                    send_text("fun");
            end
            3:
            begin
                if ($urandom_range(1))
                    send_text("retur");
                else
                    send_text("returns");
            end
            default:
            begin
                n = $urandom_range(7);
                send_byte(WORD_TEXT[$urandom_range(52)]);
                for (int i = 0; i < n; i++)
                    send_byte(WORD_TEXT[$urandom_range(62)]);
            end
        endcase
    endtask

    task automatic gen_number();
        int n;
        bit dot;
        n = $urandom_range(1, 6);
        dot = 0;
        for (int i = 0; i < n; i++)
        begin
            send_byte(8'("0" + $urandom_range(9)));
            if (!dot && i < n - 1 && $urandom_range(3) == 0)
            begin
                send_byte(CH_DOT);
                dot = 1;
            end
        end
        if ($urandom_range(7) == 0)
            send_byte(CH_DOT);
    endtask

    task automatic gen_space();
        int r;
        r = $urandom_range(6);
        if (r >= 5)
            send_byte(r == 5 ? CH_SPACE : CH_LF);
        else
            send_byte(8'(CH_TAB + r));
    endtask

    task automatic gen_comment();
        int n;
        int r;
        n = $urandom_range(8);
        if ($urandom_range(1))
        begin
            send_text("//");
            for (int i = 0; i < n; i++)
                send_byte(8'($urandom_range(32, 126)));
            send_byte(CH_LF);
        end
        else
        begin
            send_text("/*");
            for (int i = 0; i < n; i++)
            begin
                r = $urandom_range(7);
                send_byte(r == 0 ? CH_STAR : r == 1 ? CH_SLASH : r == 2 ? CH_LF
                          : 8'($urandom_range(1, 255)));
            end
            if ($urandom_range(3) == 0)
                send_text("**/");
            else
                send_text("*/");
        end
    endtask

    task automatic gen_random();
        int pick;
        pick = $urandom_range(99);
        if (pick < 22)
            gen_word();
        else if (pick < 40)
            gen_number();
        else if (pick < 58)
            send_byte(OP_TEXT[$urandom_range(11)]);
        else if (pick < 72)
            gen_space();
        else if (pick < 86)
            gen_comment();
        else
            send_byte(8'($urandom_range(1, 255)));
    endtask

    initial
    begin
        int target;
        rst_n <= 1'b0;
        byte_in.valid <= 1'b0;
        byte_in.byte_req <= CH_NUL;
        byte_in.last <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // operators, second dot, high byte, star-slash overlap, whitespace
        send_text("+-*/^=(){},;9.5.");
        send_byte(8'hFF);
        send_text("/*/*/");
        for (int b = CH_TAB; b <= CH_CR; b++)
            send_byte(8'(b));
        send_byte(CH_SPACE);
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = (ph == 1) ? 57 : (ph == 3) ? 20 : 0;
            stall_pct = (ph == 2) ? 57 : (ph == 3) ? 20 : 0;
            target = sent_count + PHASE_BYTES;
            while (sent_count < target)
                gen_random();
            wait_drained();
        end

        // keywords on two lines
        idle_pct = 0;
        stall_pct = 0;
        send_text("x1 = func(2);\nreturn x1;");
        wait_drained();

        idle_pct = 20;
        stall_pct = 20;
        case ($urandom_range(3))
            0:
            begin
                send_text("a ");
                send_byte(CH_SLASH, 1'b1);
            end
            1:
            begin
                send_text("/* open");
                send_byte(CH_NUL);
            end
            2:
            begin
                send_text("abc");
                send_byte("d", 1'b1);
            end
            default:
            begin
                send_text("// open");
                send_byte(CH_NUL, 1'b1);
            end
        endcase
        for (int i = 0; i < 16; i++)
            send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
        send_byte(CH_NUL, 1'b1);
        wait_drained();
        repeat (20) @(posedge clk);

        if (sb.pending_tokens.size() != 0)
        begin
            $display("%0t: %0d expected tokens never arrived", $time,
                     sb.pending_tokens.size());
            sb.errors++;
        end
        $display("Covered %0d bytes (%0d after end of input) and %0d token records",
                 sb.bytes_taken, sb.bytes_dropped, sb.tokens_matched);
        $display("Token kinds observed: %0d of 18, under idle and stall mixes",
                 $countones(sb.kinds_seen));
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
